// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS     = 256;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = 9;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ENTRY_W   = 1 + KEY_W + VAL_W;
  localparam int MOD_BITS  = 4;
  localparam int MOD_CYC   = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_CYC);

  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_ASSIGN     = 3'd1;
  localparam logic [2:0] CMD_SEARCH     = 3'd2;
  localparam logic [2:0] CMD_ERASE      = 3'd3;
  localparam logic [2:0] CMD_HAS_VALUE  = 3'd4;
  localparam logic [2:0] CMD_COUNT_HOME = 3'd5;
  localparam logic [2:0] CMD_COUNT_DISP = 3'd6;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_DUPLICATE = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_FOUND     = 3'd4;
  localparam logic [2:0] STAT_MISSING   = 3'd5;

  typedef struct packed {
    logic [2:0]       command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lpht_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] tally;
    logic [CNT_W-1:0] live_entries;
  } lpht_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PRD,
    ST_PCHK,
    ST_SRD,
    ST_SCHK,
    ST_SMOD,
    ST_DONE
  } lpht_state_t;

endpackage

// File: rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative remainder unit: 32-bit key modulo a 9-bit table size,
// restoring division a few bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lpht_pkg::KEY_W-1:0]      dividend,
  input  logic [lpht_pkg::CNT_W-1:0]      divisor,
  output logic                            done,
  output logic [lpht_pkg::IDX_W-1:0]      rem
);
  import lpht_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  always_comb begin
    logic [CNT_W-1:0] r;
    logic [KEY_W-1:0] q;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    r        = rem_r;
    q        = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so one shift fits in 9 bits
      for (int i = 0; i < MOD_BITS; i++) begin
        r = {r[CNT_W-2:0], q[KEY_W-1]};
        q = {q[KEY_W-2:0], 1'b0};
        if (r >= div_r) begin
          r = r - div_r;
        end
      end
      rem_nxt = r;
      quo_nxt = q;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MOD_CNT_W'(MOD_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[IDX_W-1:0];

endmodule

// File: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall  | lpht_in_t  (command, key, value)
//  out_    | output    | out_valid/out_stall| lpht_out_t (status, value_out,
//          |           |                    |   tally, live_entries)
//  cfg_    | input     | cfg_valid/cfg_ready| table_size, 9 bits
//
//  one item at a time; a hash runs in the remainder unit (4 bits/cycle)
//  a probe reads each visited slot from RAM and then checks it; insert,
//  search and erase visit at most n slots for table size n, contains_value
//  scans the slots in order, and the count commands work out one remainder
//  per counted slot
//  reset clears the occupied flags at once; no clearing pass is needed
//  a waiting result is held in the output register while the next item starts
module linear_probe_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lpht_pkg::lpht_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lpht_pkg::lpht_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_data
);
  import lpht_pkg::*;

  lpht_state_t      state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] home_r, home_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [2:0]       stat_r, stat_nxt;
  logic [VAL_W-1:0] vout_r, vout_nxt;
  logic [CNT_W-1:0] size_r;
  logic [SLOTS-1:0] occ_r;
  logic             out_valid_r, out_valid_nxt;
  lpht_out_t        out_r, out_nxt;

  logic             occ_set;
  logic [IDX_W-1:0] occ_idx;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic             rtomb;
  logic [KEY_W-1:0] rkey;
  logic [VAL_W-1:0] rval;
  logic             mod_start, mod_done;
  logic [KEY_W-1:0] mod_arg;
  logic [IDX_W-1:0] mod_rem;
  logic [CNT_W-1:0] eff_size;
  logic             in_acc;
  logic             occ_here, live_here, last_step, last_idx;
  logic [IDX_W-1:0] idx_inc;

  assign {rtomb, rkey, rval} = ram_rdata;

  lpht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // the hash started at accept takes the size directly, n_r is loaded in the same edge
  lpht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_arg),
    .divisor  (in_acc ? eff_size : n_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // clamp the size register into 1..SLOTS
  always_comb begin
    if (size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if ({1'b0, size_r} > (CNT_W + 1)'(SLOTS)) begin
      eff_size = CNT_W'(SLOTS);
    end else begin
      eff_size = size_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign occ_here  = occ_r[idx_r];
  assign live_here = occ_here && !rtomb;
  assign last_step = (step_r + 1'b1) == n_r;
  assign last_idx  = ({1'b0, idx_r} + 1'b1) == n_r;
  assign idx_inc   = last_idx ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      size_r      <= CNT_W'(SLOTS);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      if (occ_set) begin
        occ_r[occ_idx] <= 1'b1;
      end
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    step_r     <= step_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    home_r     <= home_nxt;
    tally_r    <= tally_nxt;
    stat_r     <= stat_nxt;
    vout_r     <= vout_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    logic             free_ok;
    logic [IDX_W-1:0] fidx;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    home_nxt      = home_r;
    tally_nxt     = tally_r;
    live_nxt      = live_r;
    stat_nxt      = stat_r;
    vout_nxt      = vout_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    occ_set       = 1'b0;
    occ_idx       = idx_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {1'b0, key_r, val_r};
    mod_start     = 1'b0;
    mod_arg       = key_r;
    free_ok       = 1'b0;
    fidx          = free_vld_r ? free_idx_r : idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_data.command;
          key_nxt      = in_data.key;
          val_nxt      = in_data.value;
          n_nxt        = eff_size;
          idx_nxt      = '0;
          step_nxt     = '0;
          free_vld_nxt = 1'b0;
          tally_nxt    = '0;
          stat_nxt     = STAT_MISSING;
          vout_nxt     = '0;
          case (in_data.command) inside
            CMD_INSERT, CMD_ASSIGN, CMD_SEARCH, CMD_ERASE, CMD_COUNT_HOME: begin
              mod_start = 1'b1;
              mod_arg   = in_data.key;
              state_nxt = ST_HASH;
            end
            CMD_HAS_VALUE, CMD_COUNT_DISP: begin
              state_nxt = ST_SRD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_HASH: begin
        if (mod_done) begin
          if (cmd_r == CMD_COUNT_HOME) begin
            home_nxt  = mod_rem;
            state_nxt = ST_SRD;
          end else begin
            idx_nxt   = mod_rem;
            state_nxt = ST_PRD;
          end
        end
      end

      ST_PRD: begin
        ram_re    = 1'b1;
        state_nxt = ST_PCHK;
      end

      ST_PCHK: begin
        if (occ_here && !rtomb && rkey == key_r) begin
          state_nxt = ST_DONE;
          case (cmd_r)
            CMD_INSERT: begin
              stat_nxt = STAT_DUPLICATE;
            end
            CMD_ASSIGN: begin
              ram_we   = 1'b1;
              stat_nxt = STAT_UPDATED;
            end
            CMD_SEARCH: begin
              stat_nxt = STAT_FOUND;
              vout_nxt = rval;
            end
            default: begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, rkey, rval};
              live_nxt  = live_r - 1'b1;
              stat_nxt  = STAT_FOUND;
            end
          endcase
        end else if (!occ_here || last_step) begin
          // end of the cluster or last slot: insert/assign place a new entry in the first free slot seen
          free_ok   = free_vld_r || !occ_here || rtomb;
          state_nxt = ST_DONE;
          if (cmd_r == CMD_INSERT || cmd_r == CMD_ASSIGN) begin
            if (free_ok) begin
              ram_we    = 1'b1;
              ram_waddr = fidx;
              occ_set   = 1'b1;
              occ_idx   = fidx;
              live_nxt  = live_r + 1'b1;
              stat_nxt  = STAT_INSERTED;
            end else begin
              stat_nxt = STAT_FULL;
            end
          end
        end else begin
          if (rtomb && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
          step_nxt  = step_r + 1'b1;
          idx_nxt   = idx_inc;
          state_nxt = ST_PRD;
        end
      end

      ST_SRD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCHK;
      end

      ST_SCHK: begin
        if (cmd_r == CMD_HAS_VALUE) begin
          if (live_here && rval == val_r) begin
            stat_nxt  = STAT_FOUND;
            state_nxt = ST_DONE;
          end else if (last_idx) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_SRD;
          end
        end else if ((cmd_r == CMD_COUNT_HOME) ? occ_here : live_here) begin
          mod_start = 1'b1;
          mod_arg   = rkey;
          state_nxt = ST_SMOD;
        end else if (last_idx) begin
          stat_nxt  = STAT_FOUND;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SRD;
        end
      end

      ST_SMOD: begin
        if (mod_done) begin
          if ((cmd_r == CMD_COUNT_HOME) ? (mod_rem == home_r) : (mod_rem != idx_r)) begin
            tally_nxt = tally_r + 1'b1;
          end
          if (last_idx) begin
            stat_nxt  = STAT_FOUND;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_SRD;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = stat_r;
          out_nxt.value_out    = vout_r;
          out_nxt.tally        = tally_r;
          out_nxt.live_entries = live_r;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input lpht_pkg::lpht_in_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input lpht_pkg::lpht_out_t  out_data
);
  import lpht_pkg::*;

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STAT_MISSING)
    else $error("status code out of range");

  // counts only come with the found status
  a_tally_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tally != '0 |-> out_data.status == STAT_FOUND)
    else $error("tally without found status");

  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_out != '0 |-> out_data.status == STAT_FOUND)
    else $error("value without found status");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear-probing hash table. A queue-fed driver
// offers commands under random gaps, a monitor checks every result against
// a behavioral model of the table, and the table size is changed between
// phases, including a full table and out-of-range sizes.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lpht_in_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lpht_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  linear_probe_hash_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key [SLOTS];
  logic [VAL_W-1:0] shadow_val [SLOTS];
  bit               shadow_used [SLOTS];
  bit               shadow_dead [SLOTS];
  int unsigned      shadow_live = 0;
  int unsigned      size_reg = SLOTS;

  lpht_in_t  pending_items[$];
  lpht_out_t expected_results[$];
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_errors = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  function automatic int unsigned active_slots();
    if (size_reg == 0) return 1;
    if (size_reg > SLOTS) return SLOTS;
    return size_reg;
  endfunction

  function automatic int find_live_key(logic [KEY_W-1:0] key, int unsigned n);
    int unsigned idx;
    idx = key % n;
    for (int unsigned s = 0; s < n; s++) begin
      if (!shadow_used[idx]) return -1;
      if (!shadow_dead[idx] && shadow_key[idx] == key) return idx;
      idx = (idx + 1) % n;
    end
    return -1;
  endfunction

  function automatic logic [2:0] place_entry(logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                                             int unsigned n);
    int unsigned idx;
    idx = key % n;
    for (int unsigned s = 0; s < n; s++) begin
      if (!shadow_used[idx] || shadow_dead[idx]) begin
        shadow_key[idx]  = key;
        shadow_val[idx]  = val;
        shadow_used[idx] = 1'b1;
        shadow_dead[idx] = 1'b0;
        shadow_live++;
        return STAT_INSERTED;
      end
      idx = (idx + 1) % n;
    end
    return STAT_FULL;
  endfunction

  function automatic lpht_out_t apply_command(lpht_in_t it);
    lpht_out_t   r;
    int unsigned n;
    int          hit;
    int unsigned cnt;
    n = active_slots();
    r = '0;
    r.status = STAT_MISSING;
    cnt = 0;
    case (it.command)
      CMD_INSERT: begin
        if (find_live_key(it.key, n) >= 0) r.status = STAT_DUPLICATE;
        else r.status = place_entry(it.key, it.value, n);
      end
      CMD_ASSIGN: begin
        hit = find_live_key(it.key, n);
        if (hit >= 0) begin
          shadow_val[hit] = it.value;
          r.status = STAT_UPDATED;
        end else begin
          r.status = place_entry(it.key, it.value, n);
        end
      end
      CMD_SEARCH: begin
        hit = find_live_key(it.key, n);
        if (hit >= 0) begin
          r.status = STAT_FOUND;
          r.value_out = shadow_val[hit];
        end
      end
      CMD_ERASE: begin
        hit = find_live_key(it.key, n);
        if (hit >= 0) begin
          shadow_dead[hit] = 1'b1;
          shadow_live--;
          r.status = STAT_FOUND;
        end
      end
      CMD_HAS_VALUE: begin
        for (int unsigned i = 0; i < n; i++)
          if (shadow_used[i] && !shadow_dead[i] && shadow_val[i] == it.value)
            r.status = STAT_FOUND;
      end
      CMD_COUNT_HOME: begin
        for (int unsigned i = 0; i < n; i++)
          if (shadow_used[i] && shadow_key[i] % n == it.key % n) cnt++;
        r.status = STAT_FOUND;
      end
      CMD_COUNT_DISP: begin
        for (int unsigned i = 0; i < n; i++)
          if (shadow_used[i] && !shadow_dead[i] && shadow_key[i] % n != i) cnt++;
        r.status = STAT_FOUND;
      end
      default: ;
    endcase
    r.tally = cnt[CNT_W-1:0];
    r.live_entries = shadow_live[CNT_W-1:0];
    return r;
  endfunction

  // idle percentages move through three modes as the run progresses
  function automatic int send_idle_pct();
    if (n_accepted < 600) return 10;
    if (n_accepted < 1200) return 47;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_accepted < 600) return 47;
    if (n_accepted < 1200) return 10;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(apply_command(in_data));
      n_accepted++;
    end
  end

  // long hold-off once, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (n_accepted >= 700 && !hold_done) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
      out_stall <= (hold_left != 0) || (n_accepted >= 700 && !hold_done) ||
                   ($urandom_range(99) < recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    lpht_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0h, got %0h", want.value_out, out_data.value_out);
          n_errors++;
        end
        if (out_data.tally !== want.tally) begin
          $error("tally: expected %0d, got %0d", want.tally, out_data.tally);
          n_errors++;
        end
        if (out_data.live_entries !== want.live_entries) begin
          $error("live_entries: expected %0d, got %0d", want.live_entries,
                 out_data.live_entries);
          n_errors++;
        end
      end
    end
  end

  task automatic queue_item(logic [2:0] cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    lpht_in_t it;
    it.command = cmd;
    it.key     = key;
    it.value   = val;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_size(logic [CNT_W-1:0] sz);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    size_reg = sz;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int count);
    int unsigned n;
    int          pick;
    logic [2:0]  cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    n = active_slots();
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 25) cmd = CMD_INSERT;
      else if (pick < 45) cmd = CMD_ASSIGN;
      else if (pick < 60) cmd = CMD_SEARCH;
      else if (pick < 75) cmd = CMD_ERASE;
      else if (pick < 83) cmd = CMD_HAS_VALUE;
      else if (pick < 89) cmd = CMD_COUNT_HOME;
      else if (pick < 95) cmd = CMD_COUNT_DISP;
      else cmd = CMD_UNUSED;
      pick = $urandom_range(9);
      // small keys crowd the same home slots
      if (pick < 7) key = $urandom_range(3 * n);
      else if (pick < 9) key = $urandom();
      else key = 32'hFFFF_FFFF - $urandom_range(n);
      val = $urandom_range(1) ? $urandom() : $urandom_range(7);
      queue_item(cmd, key, val);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, tombstone reuse, unused code
    queue_item(CMD_INSERT, 32'd0, 32'd0);
    queue_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_INSERT, 32'd0, 32'd5);
    queue_item(CMD_ASSIGN, 32'd0, 32'd123);
    queue_item(CMD_ASSIGN, 32'd256, 32'hA5A5_5A5A);
    queue_item(CMD_SEARCH, 32'd0, 32'd0);
    queue_item(CMD_SEARCH, 32'hFFFF_FFFF, 32'd0);
    queue_item(CMD_SEARCH, 32'd512, 32'd0);
    queue_item(CMD_HAS_VALUE, 32'd0, 32'hFFFF_FFFF);
    queue_item(CMD_HAS_VALUE, 32'd0, 32'd77);
    queue_item(CMD_COUNT_HOME, 32'd0, 32'd0);
    queue_item(CMD_COUNT_DISP, 32'd0, 32'd0);
    queue_item(CMD_ERASE, 32'd0, 32'd0);
    queue_item(CMD_ERASE, 32'd0, 32'd0);
    queue_item(CMD_SEARCH, 32'd256, 32'd0);
    queue_item(CMD_INSERT, 32'd512, 32'd9);
    queue_item(CMD_ERASE, 32'd256, 32'd0);
    queue_item(CMD_COUNT_HOME, 32'd512, 32'd0);
    queue_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_ERASE, 32'hFFFF_FFFF, 32'd0);
    queue_item(CMD_ERASE, 32'd512, 32'd0);
    queue_item(CMD_COUNT_DISP, 32'd0, 32'd0);
    wait_drained();

    // fill every slot from one home slot, then overflow
    for (int k = 1; k <= SLOTS; k++) queue_item(CMD_INSERT, (k << 8) | 32'h5A, k);
    queue_item(CMD_COUNT_HOME, 32'h5A, 32'd0);
    queue_item(CMD_COUNT_DISP, 32'd0, 32'd0);
    queue_item(CMD_INSERT, 32'h1234_5678, 32'd1);
    queue_item(CMD_ASSIGN, 32'h1234_5678, 32'd1);
    queue_item(CMD_ASSIGN, 32'h15A, 32'hFFFF_FFFF);
    wait_drained();

    // shrink onto the full table, then walk through other sizes
    write_size(9'd1);
    queue_random(80);
    wait_drained();
    write_size(9'd0);
    queue_random(80);
    wait_drained();
    write_size(9'd2);
    queue_random(120);
    wait_drained();
    write_size(9'd3);
    queue_random(120);
    wait_drained();
    write_size(9'd7);
    queue_random(140);
    wait_drained();
    write_size(9'd16);
    queue_random(150);
    wait_drained();
    write_size(9'd5);
    queue_random(150);
    wait_drained();
    write_size(9'd31);
    queue_random(140);
    wait_drained();
    write_size(9'd511);
    queue_random(80);
    wait_drained();
    write_size(9'd64);
    queue_random(150);
    wait_drained();
    write_size(9'd256);
    queue_random(60);
    wait_drained();
    write_size(9'd300);
    queue_random(60);
    wait_drained();
    write_size(9'd13);
    queue_random(150);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("%0d commands accepted, %0d results checked, %0d mismatches",
             n_accepted, n_results, n_errors);
    $display("table sizes from 0 to 511 clamped, full table and tombstone reuse covered");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_mod.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
sim/tb_linear_probe_hash_table.sv
